/* src/lctc_pkg.sv */
// ----------------------------------------------------------------------------
// lctc_pkg
// Shared types, constants and helper functions for the Luhn card check.
// ----------------------------------------------------------------------------
package lctc_pkg;

  localparam int unsigned CardW       = 54;
  localparam int unsigned NumDigits   = 17;
  localparam int unsigned BcdW        = 4 * NumDigits;
  localparam int unsigned BitsPerStep = 3;
  localparam int unsigned ConvSteps   = CardW / BitsPerStep;
  localparam int unsigned ScanSteps   = NumDigits;
  localparam int unsigned MinDigits   = 13;
  localparam int unsigned MaxDigits   = 16;
  localparam int unsigned CountW      = 5;

  typedef logic [BcdW-1:0]   bcd_t;
  typedef logic [CountW-1:0] cnt_t;
  typedef logic [3:0]        digit_t;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_PFX3 = 2'd1,
    CLS_PFX5 = 2'd2,
    CLS_PFX4 = 2'd3
  } card_class_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } lctc_state_e;

  // One shift-add-3 step: adjust every BCD digit, then shift in one bit.
  function automatic bcd_t dd_step(bcd_t v, logic b);
    bcd_t a;
    for (int i = 0; i < NumDigits; i++) begin
      a[4*i +: 4] = (v[4*i +: 4] >= 4'd5) ? v[4*i +: 4] + 4'd3 : v[4*i +: 4];
    end
    return {a[BcdW-2:0], b};
  endfunction

  // Digit sum of a doubled decimal digit.
  function automatic digit_t luhn_dbl(digit_t d);
    logic [4:0] t;
    t = {d, 1'b0};
    return (d < 4'd5) ? digit_t'(t) : digit_t'(t - 5'd9);
  endfunction

endpackage

/* src/luhn_card_type_check.sv */
// ----------------------------------------------------------------------------
// luhn_card_type_check
// Converts a binary card number to decimal, forms the Luhn sum and count,
// and classes a passing number by its leading digits.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  input   | in_valid_i, in_stall_o, card_number_i     | sink
//  output  | out_valid_o, out_stall_i, card_class_o,   | source
//          | luhn_ok_o, digit_count_o                  |
//
//  An item passes from acceptance to its result in the output register
//  through shift-add-3 conversion, three bits per cycle, then the Luhn
//  scan, one digit per cycle, then a classify step.
//  in_stall_o is high while an item is converted, scanned or waiting for a
//  full output register. A result waits in the output register while
//  out_stall_i is high; the next item can be accepted meanwhile.
//  rst_ni clears the sequencer and the output valid flag at once.
// ----------------------------------------------------------------------------
module luhn_card_type_check import lctc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CardW-1:0] card_number_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       card_class_o,
  output logic             luhn_ok_o,
  output logic [4:0]       digit_count_o
);

  localparam cnt_t ConvLast = cnt_t'(ConvSteps - 1);
  localparam cnt_t ScanLast = cnt_t'(ScanSteps - 1);
  localparam cnt_t MinCnt   = cnt_t'(MinDigits);
  localparam cnt_t MaxCnt   = cnt_t'(MaxDigits);

  lctc_state_e      state_q, state_d;
  cnt_t             cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [CardW-1:0] bin_q;
  bcd_t             bcd_q;
  digit_t           sum_q, prev_q, hi_q, lo_q;
  cnt_t             count_q;
  logic [1:0]       card_class_q;
  logic             luhn_ok_q;
  cnt_t             digit_count_q;

  logic             accept;
  logic             emit_go;
  bcd_t             bcd_conv;
  digit_t           dig;
  digit_t           contrib;
  logic [4:0]       sum_raw;
  digit_t           sum_d;
  logic             len_ok;
  card_class_e      cls;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_q == ConvLast) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == ScanLast) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    emit_go    = 1'b0;
    cnt_d      = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cnt_d      = '0;
      end
      ST_CONV: begin
        cnt_d = (cnt_q == ConvLast) ? '0 : cnt_q + cnt_t'(1);
      end
      ST_SCAN: begin
        cnt_d = cnt_q + cnt_t'(1);
      end
      ST_EMIT: begin
        emit_go = !out_valid_q || !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign bcd_conv = dd_step(dd_step(dd_step(bcd_q, bin_q[CardW-1]), bin_q[CardW-2]),
                            bin_q[CardW-3]);
  assign dig      = bcd_q[3:0];
  assign contrib  = cnt_q[0] ? luhn_dbl(dig) : dig;
  assign sum_raw  = {1'b0, sum_q} + {1'b0, contrib};
  assign sum_d    = (sum_raw >= 5'd10) ? digit_t'(sum_raw - 5'd10) : digit_t'(sum_raw);

  assign len_ok = (count_q >= MinCnt) && (count_q <= MaxCnt);

  always_comb begin
    cls = CLS_NONE;
    if (len_ok && (sum_q == 4'd0)) begin
      if ((hi_q == 4'd3) && ((lo_q == 4'd4) || (lo_q == 4'd7))) begin
        cls = CLS_PFX3;
      end else if ((hi_q == 4'd5) && (lo_q >= 4'd1) && (lo_q <= 4'd5)) begin
        cls = CLS_PFX5;
      end else if (hi_q == 4'd4) begin
        cls = CLS_PFX4;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_q   <= card_number_i;
      bcd_q   <= '0;
      sum_q   <= '0;
      prev_q  <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      count_q <= cnt_t'(1);
    end else if (state_q == ST_CONV) begin
      bcd_q <= bcd_conv;
      bin_q <= {bin_q[CardW-BitsPerStep-1:0], {BitsPerStep{1'b0}}};
    end else if (state_q == ST_SCAN) begin
      bcd_q  <= {4'd0, bcd_q[BcdW-1:4]};
      sum_q  <= sum_d;
      prev_q <= dig;
      if (dig != 4'd0) begin
        count_q <= cnt_q + cnt_t'(1);
        hi_q    <= dig;
        lo_q    <= prev_q;
      end
    end
    if (emit_go) begin
      card_class_q  <= cls;
      luhn_ok_q     <= (sum_q == 4'd0);
      digit_count_q <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign card_class_o  = card_class_q;
  assign luhn_ok_o     = luhn_ok_q;
  assign digit_count_o = digit_count_q;

endmodule

/* src/lctc_checker.sv */
// ----------------------------------------------------------------------------
// lctc_checker
// Port-level checks for the Luhn card check, bound to the top level.
// ----------------------------------------------------------------------------
module lctc_checker import lctc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       card_class_o,
  input logic             luhn_ok_o,
  input logic [4:0]       digit_count_o
);

  localparam logic [4:0] MinCnt = 5'(MinDigits);
  localparam logic [4:0] MaxCnt = 5'(MaxDigits);
  localparam logic [4:0] TopCnt = 5'(NumDigits);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(card_class_o)
      && $stable(luhn_ok_o) && $stable(digit_count_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_count_o != 5'd0) && (digit_count_o <= TopCnt))
    else $error("digit count out of range");

  a_class_needs_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (card_class_o != CLS_NONE) |-> luhn_ok_o)
    else $error("class given without Luhn pass");

  a_class_needs_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (card_class_o != CLS_NONE)
      |-> (digit_count_o >= MinCnt) && (digit_count_o <= MaxCnt))
    else $error("class given for bad length");

endmodule

bind luhn_card_type_check lctc_checker u_lctc_checker (.*);
